@@ hw/rtl/occupancy_cell_rigid_remap_macros.svh @@
// Assertion macros for the occupancy cell remap block.
// Each use stands on a line of its own inside a checker module.
`ifndef OCCUPANCY_CELL_RIGID_REMAP_MACROS_SVH
`define OCCUPANCY_CELL_RIGID_REMAP_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define OCRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define OCRR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ocrr_pkg.sv @@
// ----------------------------------------------------------------------------
// ocrr_pkg
// Shared widths, register indexes, reset values and the configuration
// struct of the occupancy cell remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package ocrr_pkg;

  // Field widths
  localparam int IDX_W      = 16;
  localparam int OCC_W      = 8;
  localparam int COEF_W     = 24;
  localparam int OFF_W      = 32;
  localparam int THR_W      = 7;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int FRAC_SHIFT = 17;

  // Default for the index width parameter
  localparam int INDEX_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LETHAL   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNK_FREE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH = 4'd7;

  // Reset values
  localparam logic [COEF_W-1:0] ROT_COS_RST = 24'd65536;
  localparam logic [THR_W-1:0]  LETHAL_RST  = 7'd95;

  // Cost kinds
  localparam logic COST_FREE   = 1'b0;
  localparam logic COST_LETHAL = 1'b1;

  typedef struct packed {
    logic [COEF_W-1:0] rot_cos;
    logic [COEF_W-1:0] rot_sin;
    logic [OFF_W-1:0]  off_x;
    logic [OFF_W-1:0]  off_y;
    logic [THR_W-1:0]  lethal_thr;
    logic              free_unknown;
    logic [IDX_W-1:0]  lo_col;
    logic [IDX_W-1:0]  lo_row;
    logic [IDX_W-1:0]  hi_col;
    logic [IDX_W-1:0]  hi_row;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/ocrr_stream_if.sv @@
// ----------------------------------------------------------------------------
// ocrr_stream_if
// Valid/ready channels: source cells in, map cell updates out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocrr_cell_if;
  logic                               valid;
  logic                               ready;
  logic [ocrr_pkg::IDX_W-1:0]         cell_col;
  logic [ocrr_pkg::IDX_W-1:0]         cell_row;
  logic signed [ocrr_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, cell_col, cell_row, occupancy, input ready);
  modport sink   (input valid, cell_col, cell_row, occupancy, output ready);
endinterface

interface ocrr_map_if;
  logic                       valid;
  logic                       ready;
  logic [ocrr_pkg::IDX_W-1:0] map_col;
  logic [ocrr_pkg::IDX_W-1:0] map_row;
  logic                       cost_kind;

  modport source (output valid, map_col, map_row, cost_kind, input ready);
  modport sink   (input valid, map_col, map_row, cost_kind, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/occupancy_cell_rigid_remap.sv @@
// Occupancy cell remap: use of the block
// The cells channel (valid/ready) carries one source grid cell per transfer:
// column, row and signed occupancy. The updates channel carries one master
// map cell per transfer: column, row and cost kind (0 free, 1 lethal).
// A source cell yields one update or none: unknown cells without the free
// flag, cells below the lethal threshold and cells that land outside the
// update window or at a negative position give no update.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_data), written
// while no cell is in flight.
// Throughput: one cell per cycle while the receiver takes updates, set by
// the four-stage pipeline (classify, multiply, sum, window check with output
// register); each cell passes the stages in that order.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: unit rotation, no offset, threshold 95, empty window.
// When the receiver holds ready low the output holds; the stages behind it
// keep filling until each holds an item, then cells ready drops.
// ----------------------------------------------------------------------------
// occupancy_cell_rigid_remap
// Top level: config registers and the four-stage remap pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_cell_rigid_remap #(
  parameter int INDEX_BITS = ocrr_pkg::INDEX_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ocrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ocrr_pkg::CFG_W-1:0]      cfg_data,
  ocrr_cell_if.sink                            cells,
  ocrr_map_if.source                           updates
);

  localparam int SUM_W = ocrr_pkg::COEF_W + INDEX_BITS + 4;

  ocrr_pkg::cfg_t          cfg;
  logic                    s1_valid;
  logic                    s1_ready;
  logic [INDEX_BITS:0]     s1_pc;
  logic [INDEX_BITS:0]     s1_pr;
  logic                    s1_kind;
  logic                    s3_valid;
  logic                    s3_ready;
  logic signed [SUM_W-1:0] s3_u;
  logic signed [SUM_W-1:0] s3_v;
  logic                    s3_kind;

  ocrr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ocrr_classify #(.INDEX_BITS(INDEX_BITS)) u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cells.valid),
    .in_ready  (cells.ready),
    .cell_col  (cells.cell_col),
    .cell_row  (cells.cell_row),
    .occupancy (cells.occupancy),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_pc     (s1_pc),
    .s1_pr     (s1_pr),
    .s1_kind   (s1_kind)
  );

  ocrr_xform #(.INDEX_BITS(INDEX_BITS), .SUM_W(SUM_W)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_pc    (s1_pc),
    .s1_pr    (s1_pr),
    .s1_kind  (s1_kind),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3_u     (s3_u),
    .s3_v     (s3_v),
    .s3_kind  (s3_kind)
  );

  ocrr_window #(.INDEX_BITS(INDEX_BITS), .SUM_W(SUM_W)) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s3_valid  (s3_valid),
    .s3_ready  (s3_ready),
    .s3_u      (s3_u),
    .s3_v      (s3_v),
    .s3_kind   (s3_kind),
    .out_valid (updates.valid),
    .out_ready (updates.ready),
    .out_col   (updates.map_col),
    .out_row   (updates.map_row),
    .out_kind  (updates.cost_kind)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ocrr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ocrr_cfg_regs
// Configuration register file, write only. Unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrr_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ocrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ocrr_pkg::CFG_W-1:0]        cfg_data,
  output ocrr_pkg::cfg_t                         cfg
);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot_cos      <= ocrr_pkg::ROT_COS_RST;
      cfg.rot_sin      <= '0;
      cfg.off_x        <= '0;
      cfg.off_y        <= '0;
      cfg.lethal_thr   <= ocrr_pkg::LETHAL_RST;
      cfg.free_unknown <= 1'b0;
      cfg.lo_col       <= '0;
      cfg.lo_row       <= '0;
      cfg.hi_col       <= '0;
      cfg.hi_row       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ocrr_pkg::REG_ROT_COS:  cfg.rot_cos      <= cfg_data[ocrr_pkg::COEF_W-1:0];
        ocrr_pkg::REG_ROT_SIN:  cfg.rot_sin      <= cfg_data[ocrr_pkg::COEF_W-1:0];
        ocrr_pkg::REG_OFFSET_X: cfg.off_x        <= cfg_data[ocrr_pkg::OFF_W-1:0];
        ocrr_pkg::REG_OFFSET_Y: cfg.off_y        <= cfg_data[ocrr_pkg::OFF_W-1:0];
        ocrr_pkg::REG_LETHAL:   cfg.lethal_thr   <= cfg_data[ocrr_pkg::THR_W-1:0];
        ocrr_pkg::REG_UNK_FREE: cfg.free_unknown <= cfg_data[0];
        ocrr_pkg::REG_WIN_LOW: begin
          cfg.lo_col <= cfg_data[15:0];
          cfg.lo_row <= cfg_data[31:16];
        end
        ocrr_pkg::REG_WIN_HIGH: begin
          cfg.hi_col <= cfg_data[15:0];
          cfg.hi_row <= cfg_data[31:16];
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ocrr_classify.sv @@
// ----------------------------------------------------------------------------
// ocrr_classify
// Stage 1: occupancy classification and cell centre coordinates (2*i + 1).
// ----------------------------------------------------------------------------
`default_nettype none

module ocrr_classify #(
  parameter int INDEX_BITS = ocrr_pkg::INDEX_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  ocrr_pkg::cfg_t                         cfg,
  // upstream
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ocrr_pkg::IDX_W-1:0]        cell_col,
  input  wire logic [ocrr_pkg::IDX_W-1:0]        cell_row,
  input  wire logic [ocrr_pkg::OCC_W-1:0]        occupancy,
  // downstream
  output logic                                   s1_valid,
  input  wire logic                              s1_ready,
  output logic [INDEX_BITS:0]                    s1_pc,
  output logic [INDEX_BITS:0]                    s1_pr,
  output logic                                   s1_kind
);

  logic keep;
  logic kind;

  // Unknown cells follow the free flag, known cells the lethal threshold
  always_comb begin
    if (occupancy[ocrr_pkg::OCC_W-1]) begin
      keep = cfg.free_unknown;
      kind = ocrr_pkg::COST_FREE;
    end else begin
      keep = (occupancy[ocrr_pkg::THR_W-1:0] >= cfg.lethal_thr);
      kind = ocrr_pkg::COST_LETHAL;
    end
  end

  assign in_ready = !s1_valid || s1_ready;

  // Stage valid; dropped cells leave a bubble
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid && keep;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_pc   <= {cell_col[INDEX_BITS-1:0], 1'b1};
      s1_pr   <= {cell_row[INDEX_BITS-1:0], 1'b1};
      s1_kind <= kind;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ocrr_xform.sv @@
// ----------------------------------------------------------------------------
// ocrr_xform
// Stages 2 and 3: four rotation products, then the two sums with offsets.
// Results are in Q.17 master map units.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrr_xform #(
  parameter int INDEX_BITS = ocrr_pkg::INDEX_BITS_DEF,
  parameter int SUM_W      = ocrr_pkg::COEF_W + ocrr_pkg::INDEX_BITS_DEF + 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  ocrr_pkg::cfg_t             cfg,
  // upstream
  input  wire logic                  s1_valid,
  output logic                       s1_ready,
  input  wire logic [INDEX_BITS:0]   s1_pc,
  input  wire logic [INDEX_BITS:0]   s1_pr,
  input  wire logic                  s1_kind,
  // downstream
  output logic                       s3_valid,
  input  wire logic                  s3_ready,
  output logic signed [SUM_W-1:0]    s3_u,
  output logic signed [SUM_W-1:0]    s3_v,
  output logic                       s3_kind
);

  localparam int MUL_W = SUM_W - 2;

  logic                    s2_valid;
  logic                    s2_ready;
  logic                    s2_kind;
  logic signed [MUL_W-1:0] cos_pc;
  logic signed [MUL_W-1:0] sin_pr;
  logic signed [MUL_W-1:0] sin_pc;
  logic signed [MUL_W-1:0] cos_pr;

  // Stage handshake chain
  assign s2_ready = !s3_valid || s3_ready;
  assign s1_ready = !s2_valid || s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s2_valid <= s1_valid;
      if (s2_ready) s3_valid <= s2_valid;
    end
  end

  // Stage 2: products
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      cos_pc  <= $signed(cfg.rot_cos) * $signed({1'b0, s1_pc});
      sin_pr  <= $signed(cfg.rot_sin) * $signed({1'b0, s1_pr});
      sin_pc  <= $signed(cfg.rot_sin) * $signed({1'b0, s1_pc});
      cos_pr  <= $signed(cfg.rot_cos) * $signed({1'b0, s1_pr});
      s2_kind <= s1_kind;
    end
  end

  // Stage 3: sums, offsets doubled to match the Q.17 scale
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s3_u    <= SUM_W'(cos_pc) - SUM_W'(sin_pr) + SUM_W'($signed({cfg.off_x, 1'b0}));
      s3_v    <= SUM_W'(sin_pc) + SUM_W'(cos_pr) + SUM_W'($signed({cfg.off_y, 1'b0}));
      s3_kind <= s2_kind;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ocrr_window.sv @@
// ----------------------------------------------------------------------------
// ocrr_window
// Stage 4: floor, sign and update window check; holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrr_window #(
  parameter int INDEX_BITS = ocrr_pkg::INDEX_BITS_DEF,
  parameter int SUM_W      = ocrr_pkg::COEF_W + ocrr_pkg::INDEX_BITS_DEF + 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  ocrr_pkg::cfg_t                      cfg,
  // upstream
  input  wire logic                           s3_valid,
  output logic                                s3_ready,
  input  wire logic signed [SUM_W-1:0]        s3_u,
  input  wire logic signed [SUM_W-1:0]        s3_v,
  input  wire logic                           s3_kind,
  // result register
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ocrr_pkg::IDX_W-1:0]          out_col,
  output logic [ocrr_pkg::IDX_W-1:0]          out_row,
  output logic                                out_kind
);

  localparam int MW = SUM_W - 1 - ocrr_pkg::FRAC_SHIFT;

  logic [MW-1:0] mc;
  logic [MW-1:0] mr;
  logic [MW-1:0] lo_c;
  logic [MW-1:0] lo_r;
  logic [MW-1:0] hi_c;
  logic [MW-1:0] hi_r;
  logic          hit;

  // Floor of a non-negative value is a plain bit slice
  assign mc   = s3_u[SUM_W-2:ocrr_pkg::FRAC_SHIFT];
  assign mr   = s3_v[SUM_W-2:ocrr_pkg::FRAC_SHIFT];
  assign lo_c = MW'(cfg.lo_col[INDEX_BITS-1:0]);
  assign lo_r = MW'(cfg.lo_row[INDEX_BITS-1:0]);
  assign hi_c = MW'(cfg.hi_col[INDEX_BITS-1:0]);
  assign hi_r = MW'(cfg.hi_row[INDEX_BITS-1:0]);

  assign hit = !s3_u[SUM_W-1] && !s3_v[SUM_W-1] &&
               (mc >= lo_c) && (mc < hi_c) &&
               (mr >= lo_r) && (mr < hi_r);

  assign s3_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_ready) begin
      out_valid <= s3_valid && hit;
    end
  end

  // Inside the window the index fits in INDEX_BITS
  always_ff @(posedge clk) begin
    if (s3_ready) begin
      out_col  <= ocrr_pkg::IDX_W'(mc[INDEX_BITS-1:0]);
      out_row  <= ocrr_pkg::IDX_W'(mr[INDEX_BITS-1:0]);
      out_kind <= s3_kind;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ocrr_checker.sv @@
// ----------------------------------------------------------------------------
// ocrr_checker
// Port-level checks of the remap block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "occupancy_cell_rigid_remap_macros.svh"

module ocrr_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ocrr_pkg::IDX_W-1:0] map_col,
  input wire logic [ocrr_pkg::IDX_W-1:0] map_row,
  input wire logic                       cost_kind
);

  // A stalled update keeps its valid
  `OCRR_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid, "update valid dropped")

  // A stalled update keeps its payload
  `OCRR_ASSERT(a_data_hold, out_valid && !out_ready |=> $stable(map_col) && $stable(map_row) && $stable(cost_kind), "update changed while stalled")

  // An empty output register means the pipeline takes cells
  `OCRR_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "cells stalled with empty output")

  // No update within the pipeline depth after reset
  `OCRR_ASSERT_ALWAYS(a_reset_latency, $past(rst) || $past(rst, 2) || $past(rst, 3) |-> !out_valid, "update too soon after reset")

endmodule

bind occupancy_cell_rigid_remap ocrr_checker u_ocrr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (cells.ready),
  .out_valid (updates.valid),
  .out_ready (updates.ready),
  .map_col   (updates.map_col),
  .map_row   (updates.map_row),
  .cost_kind (updates.cost_kind)
);

`default_nettype wire

@@ tb/sv/map_update_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// map_update_checker
// Watches the cells and updates channels and the register write port. Each
// accepted source cell is remapped under a local copy of the registers; every
// map update that leaves the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------

module map_update_checker
  import ocrr_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  ocrr_cell_if                 cells,
  ocrr_map_if                  updates,
  output int                   fail_count,
  output int                   pending,
  output int                   update_count
);

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic             kind;
  } map_cell_t;

  localparam longint IDX_MASK = (longint'(1) << INDEX_BITS) - 1;
  localparam int     MAX_PRINTED = 30;

  cfg_t      regs;
  map_cell_t expected_updates[$];
  int        mismatches = 0;
  int        checked = 0;

  // Classify the cell, move its centre into map units, floor, window test.
  // Returns 1 when the cell writes the map.
  function automatic bit remap_cell(input cfg_t rc, input logic [IDX_W-1:0] col,
                                    input logic [IDX_W-1:0] row,
                                    input logic [OCC_W-1:0] occ, output map_cell_t upd);
    longint c, s, ox, oy, pc, pr, u, v, mc, mr;
    logic   kind;
    upd = '0;
    if (occ[OCC_W-1]) begin
      if (!rc.free_unknown) return 1'b0;
      kind = COST_FREE;
    end else if (occ[THR_W-1:0] >= rc.lethal_thr) begin
      kind = COST_LETHAL;
    end else begin
      return 1'b0;
    end
    c  = longint'($signed(rc.rot_cos));
    s  = longint'($signed(rc.rot_sin));
    ox = longint'($signed(rc.off_x));
    oy = longint'($signed(rc.off_y));
    // doubled centre coordinates keep the half-cell offset exact
    pc = 2 * (longint'(col) & IDX_MASK) + 1;
    pr = 2 * (longint'(row) & IDX_MASK) + 1;
    u  = c * pc - s * pr + 2 * ox;
    v  = s * pc + c * pr + 2 * oy;
    if (u < 0 || v < 0) return 1'b0;
    mc = u >>> FRAC_SHIFT;
    mr = v >>> FRAC_SHIFT;
    if (mc <  (longint'(rc.lo_col) & IDX_MASK) || mc >= (longint'(rc.hi_col) & IDX_MASK) ||
        mr <  (longint'(rc.lo_row) & IDX_MASK) || mr >= (longint'(rc.hi_row) & IDX_MASK))
      return 1'b0;
    upd.col  = mc[IDX_W-1:0];
    upd.row  = mr[IDX_W-1:0];
    upd.kind = kind;
    return 1'b1;
  endfunction

  task automatic report(input string what);
    if (mismatches < MAX_PRINTED) $display("[%0t] update check: %s", $realtime, what);
    mismatches++;
  endtask

  // Predict on cell transfers, compare on update transfers, track writes
  always @(posedge clk) begin : track
    map_cell_t hit;
    map_cell_t want;
    if (rst) begin
      regs            = '0;
      regs.rot_cos    = ROT_COS_RST;
      regs.lethal_thr = LETHAL_RST;
      expected_updates.delete();
    end else begin
      if (cells.valid && cells.ready) begin
        if (remap_cell(regs, cells.cell_col, cells.cell_row, cells.occupancy, hit))
          expected_updates.push_back(hit);
      end
      if (updates.valid && updates.ready) begin
        if (expected_updates.size() == 0) begin
          report($sformatf("update col %0d row %0d kind %0d with none expected",
                           updates.map_col, updates.map_row, updates.cost_kind));
        end else begin
          want = expected_updates.pop_front();
          if (updates.map_col !== want.col)
            report($sformatf("map_col %0d, expected %0d", updates.map_col, want.col));
          if (updates.map_row !== want.row)
            report($sformatf("map_row %0d, expected %0d", updates.map_row, want.row));
          if (updates.cost_kind !== want.kind)
            report($sformatf("cost_kind %0d, expected %0d", updates.cost_kind, want.kind));
          checked++;
        end
      end
      // register writes take effect for cells after this edge
      if (cfg_we) begin
        case (cfg_index)
          REG_ROT_COS:  regs.rot_cos      = cfg_data[COEF_W-1:0];
          REG_ROT_SIN:  regs.rot_sin      = cfg_data[COEF_W-1:0];
          REG_OFFSET_X: regs.off_x        = cfg_data[OFF_W-1:0];
          REG_OFFSET_Y: regs.off_y        = cfg_data[OFF_W-1:0];
          REG_LETHAL:   regs.lethal_thr   = cfg_data[THR_W-1:0];
          REG_UNK_FREE: regs.free_unknown = cfg_data[0];
          REG_WIN_LOW: begin
            regs.lo_col = cfg_data[IDX_W-1:0];
            regs.lo_row = cfg_data[CFG_W-1:IDX_W];
          end
          REG_WIN_HIGH: begin
            regs.hi_col = cfg_data[IDX_W-1:0];
            regs.hi_row = cfg_data[CFG_W-1:IDX_W];
          end
          default: ;
        endcase
      end
    end
    pending      <= expected_updates.size();
    fail_count   <= mismatches;
    update_count <= checked;
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the occupancy cell remap block. A short directed
// pass hits field extremes, the cost classes, window edges and coefficient
// extremes; then random register settings each carry a batch of random cells,
// with bursty input and a stalling receiver. Checking is in map_update_checker.
// ----------------------------------------------------------------------------

module tb_top;
  import ocrr_pkg::*;

  localparam int RANDOM_ITEMS  = 1750;
  localparam int PHASE_ITEMS   = 125;
  localparam int MIN_UPDATES   = 60;
  localparam int MAX_PHASES    = 40;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 400000;

  localparam logic [31:0] COEF_ONE  = 32'd65536;
  localparam logic [31:0] COEF_MAX  = 32'h007F_FFFF;
  localparam logic [31:0] COEF_MIN  = 32'h0080_0000;
  localparam logic [31:0] OFF_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] OFF_MIN   = 32'h8000_0000;
  localparam logic [31:0] WIN_ZERO  = 32'h0000_0000;
  localparam logic [31:0] WIN_ALL   = 32'hFFFF_FFFF;
  localparam logic [31:0] THR_DEF   = 32'd95;
  localparam logic [7:0]  OCC_UNK   = 8'hFF;
  localparam logic [7:0]  OCC_MIN   = 8'h80;

  typedef enum logic [1:0] {RX_OPEN, RX_ALTERNATE, RX_RANDOM, RX_LONG_STALL} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ocrr_cell_if cells ();
  ocrr_map_if  updates ();

  int fail_count;
  int pending;
  int update_count;
  int cells_sent     = 0;
  int settings_used  = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_max        = 2;

  occupancy_cell_rigid_remap dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells),
    .updates   (updates)
  );

  map_update_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cells        (cells),
    .updates      (updates),
    .fail_count   (fail_count),
    .pending      (pending),
    .update_count (update_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d updates outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: picks a new stall style whenever the current one runs out
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold;
    mode      = RX_OPEN;
    mode_left = 0;
    hold      = 0;
    updates.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        RX_OPEN:      updates.ready <= 1'b1;
        RX_ALTERNATE: updates.ready <= mode_left[0];
        RX_RANDOM:    updates.ready <= ($urandom_range(0, 9) > 2);
        RX_LONG_STALL: begin
          if (hold == 0) begin
            updates.ready <= 1'b1;
            hold = $urandom_range(1, 12);
          end else begin
            updates.ready <= 1'b0;
            hold--;
          end
        end
        default: updates.ready <= 1'b1;
      endcase
    end
  end

  // Write all eight registers, one per cycle
  task automatic program_regs(input logic [31:0] cos_v, input logic [31:0] sin_v,
                              input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] thr, input logic [31:0] unk,
                              input logic [31:0] wlo, input logic [31:0] whi);
    logic [CFG_W-1:0]     vals [8];
    logic [CFG_IDX_W-1:0] idxs [8];
    vals = '{cos_v, sin_v, ox, oy, thr, unk, wlo, whi};
    idxs = '{REG_ROT_COS, REG_ROT_SIN, REG_OFFSET_X, REG_OFFSET_Y,
             REG_LETHAL, REG_UNK_FREE, REG_WIN_LOW, REG_WIN_HIGH};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Idle until every predicted update is out, then let dropped cells drain
  task automatic settle();
    cells.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One cell transfer; bursts separated by random gaps when gap_max > 0
  task automatic send_cell(input logic [15:0] col, input logic [15:0] row,
                           input logic [7:0] occ);
    if (gap_max != 0 && burst_left == 0) begin
      cells.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    cells.valid     <= 1'b1;
    cells.cell_col  <= col;
    cells.cell_row  <= row;
    cells.occupancy <= occ;
    do @(posedge clk); while (!cells.ready);
    if (burst_left != 0) burst_left--;
    cells_sent++;
  endtask

  // Random register setting followed by a batch of cells
  task automatic random_phase();
    logic [31:0] cos_v, sin_v, ox, oy, thr, wlo, whi;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      // scale within +/-1.5, lands small cells near the offset
      cos_v = $urandom_range(0, 196608) - 98304;
      sin_v = $urandom_range(0, 196608) - 98304;
    end else if (pick < 8) begin
      cos_v = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
      sin_v = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
    end else begin
      cos_v = $urandom;
      sin_v = $urandom;
    end
    if ($urandom_range(0, 9) < 8) begin
      ox = ($urandom_range(8192, 24576) << 16) | $urandom_range(0, 65535);
      oy = ($urandom_range(8192, 24576) << 16) | $urandom_range(0, 65535);
    end else begin
      ox = $urandom;
      oy = $urandom;
    end
    pick = $urandom_range(0, 9);
    thr  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd127 : $urandom_range(20, 100);
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      wlo = {16'($urandom_range(0, 12000)), 16'($urandom_range(0, 12000))};
      whi = {16'($urandom_range(20000, 65535)), 16'($urandom_range(20000, 65535))};
    end else if (pick < 8) begin
      wlo = WIN_ZERO;
      whi = WIN_ALL;
    end else begin
      wlo = $urandom;
      whi = $urandom;
    end
    settle();
    program_regs(cos_v, sin_v, ox, oy, thr, $urandom_range(0, 1), wlo, whi);
    gap_max    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    burst_left = 0;
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 4) == 0)
        send_cell(16'($urandom), 16'($urandom), 8'($urandom));
      else
        send_cell(16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047)), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int directed_sent;
    int phases;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_ROT_COS;
    cfg_data        <= '0;
    cells.valid     <= 1'b0;
    cells.cell_col  <= '0;
    cells.cell_row  <= '0;
    cells.occupancy <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: window empty, unknown cells dropped
    send_cell(16'd0, 16'd0, 8'd127);
    send_cell(16'd1, 16'd1, OCC_UNK);

    // Identity transform, whole map open, unknown written as free
    settle();
    program_regs(COEF_ONE, 32'd0, 32'd0, 32'd0, THR_DEF, 32'd1, WIN_ZERO, WIN_ALL);
    send_cell(16'd0, 16'd0, 8'd95);
    send_cell(16'd0, 16'd0, 8'd94);
    send_cell(16'hFFFF, 16'hFFFF, 8'd127);   // one past the map limit
    send_cell(16'hFFFE, 16'hFFFE, 8'd127);   // last cell inside
    send_cell(16'd7, 16'd5, OCC_UNK);
    send_cell(16'd3, 16'd9, OCC_MIN);
    send_cell(16'hAAAA, 16'h5555, 8'd100);
    send_cell(16'h5555, 16'hAAAA, 8'd0);

    // Threshold zero, unknown dropped, window edge at col 2 / row 4
    settle();
    program_regs(COEF_ONE, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0004_0002, 32'h0100_0100);
    send_cell(16'd4, 16'd4, 8'd0);
    send_cell(16'd4, 16'd4, OCC_UNK);
    send_cell(16'd1, 16'd4, 8'd50);
    send_cell(16'd2, 16'd4, OCC_MIN);

    // Quarter turn with the largest column offset: negative positions
    settle();
    program_regs(32'd0, COEF_ONE, OFF_MAX, 32'd0, THR_DEF, 32'd1, WIN_ZERO, WIN_ALL);
    send_cell(16'd10, 16'd10, 8'd127);
    send_cell(16'd10, 16'd40000, 8'd127);
    send_cell(16'd10, 16'd32767, OCC_UNK);

    // Empty window
    settle();
    program_regs(COEF_ONE, 32'd0, 32'd0, 32'd0, THR_DEF, 32'd1, 32'h0010_0010, 32'h0010_0010);
    send_cell(16'd16, 16'd16, 8'd127);

    // Coefficient and offset extremes, both signs
    settle();
    program_regs(COEF_MIN, COEF_MAX, OFF_MAX, OFF_MIN, 32'd127, 32'd1, WIN_ZERO, WIN_ALL);
    send_cell(16'd0, 16'd0, 8'd127);
    send_cell(16'hFFFF, 16'hFFFF, OCC_UNK);
    settle();
    program_regs(COEF_MAX, COEF_MIN, OFF_MIN, OFF_MAX, 32'd0, 32'd1, WIN_ZERO, WIN_ALL);
    send_cell(16'd0, 16'd0, 8'd0);
    send_cell(16'hFFFF, 16'd0, OCC_MIN);

    // Random settings until enough cells and updates
    directed_sent = cells_sent;
    phases        = 0;
    while ((cells_sent - directed_sent < RANDOM_ITEMS || update_count < MIN_UPDATES) &&
           phases < MAX_PHASES) begin
      random_phase();
      phases++;
    end
    settle();

    $display("Run covered %0d source cells under %0d register settings;",
             cells_sent, settings_used);
    $display("%0d map updates were compared field by field.", update_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ocrr_pkg.sv
hw/rtl/ocrr_stream_if.sv
hw/rtl/ocrr_cfg_regs.sv
hw/rtl/ocrr_classify.sv
hw/rtl/ocrr_xform.sv
hw/rtl/ocrr_window.sv
hw/rtl/occupancy_cell_rigid_remap.sv
hw/rtl/ocrr_checker.sv
tb/sv/map_update_checker.sv
tb/sv/tb_top.sv
